// File: rtl/core/lscf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lscf_pkg
// Shared constants, types and address helper for the LED shift chain
// framebuffer.
// ----------------------------------------------------------------------------
package lscf_pkg;

	localparam int MAX_ROWS     = 64;
	localparam int MAX_COLS     = 64;
	localparam int DEPTH        = (MAX_ROWS * MAX_COLS) / 8;
	localparam int AW           = $clog2(DEPTH);
	localparam int ROW_BYTES    = MAX_ROWS / 8;
	localparam int KCNT_W       = $clog2(ROW_BYTES) + 1;
	localparam int CIDX_W       = $clog2(MAX_COLS);
	localparam int GEO_W        = 7;
	localparam int BITS_W       = 64;
	localparam int COLIDX_W     = 6;
	localparam int DUTY_W       = 8;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 8;
	localparam int ADDR_SUM_W   = 2 * GEO_W + 1;

	typedef enum logic [1:0] {
		OP_SET     = 2'd0,
		OP_READ    = 2'd1,
		OP_CLEAR   = 2'd2,
		OP_REFRESH = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NUM_ROWS   = 3'd0,
		REG_NUM_COLS   = 3'd1,
		REG_BRIGHTNESS = 3'd2,
		REG_INVERT     = 3'd3,
		REG_ENABLE     = 3'd4
	} cfg_reg_t;

	localparam logic KIND_READ  = 1'b0;
	localparam logic KIND_SHIFT = 1'b1;

	typedef struct packed {
		logic [GEO_W-1:0]  rows;
		logic [GEO_W-1:0]  cols;
		logic [DUTY_W-1:0] brightness;
		logic              invert;
		logic              enable;
	} cfg_t;

	typedef struct packed {
		logic                kind;
		logic                pixel_read;
		logic [BITS_W-1:0]   column_bits;
		logic [COLIDX_W-1:0] column_index;
		logic                last;
		logic [DUTY_W-1:0]   oe_duty;
	} res_t;

	typedef struct packed {
		logic          rd_en;
		logic [AW-1:0] rd_addr;
		logic          wr_en;
		logic [AW-1:0] wr_addr;
		logic [7:0]    wr_data;
	} ram_req_t;

	// byte address of a pixel: floor(col*rows/8) + floor(row/8)
	function automatic logic [ADDR_SUM_W-1:0] locate_addr(
		input logic [GEO_W-1:0] c,
		input logic [GEO_W-1:0] r,
		input logic [GEO_W-1:0] rows
	);
		logic [2*GEO_W-1:0] prod;
		prod = c * rows;
		return ADDR_SUM_W'(prod >> 3) + ADDR_SUM_W'(r >> 3);
	endfunction

endpackage

// File: rtl/core/lscf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lscf_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module lscf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: rtl/core/lscf_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lscf_cfg
// Configuration registers with geometry saturated to the store limits.
// ----------------------------------------------------------------------------
module lscf_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [lscf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lscf_pkg::CFG_DATA_W-1:0]    cfg_data,
	output lscf_pkg::cfg_t                     cfg
);

	logic [lscf_pkg::GEO_W-1:0]  num_rows_q;
	logic [lscf_pkg::GEO_W-1:0]  num_cols_q;
	logic [lscf_pkg::DUTY_W-1:0] brightness_q;
	logic                        invert_q;
	logic                        enable_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q   <= lscf_pkg::GEO_W'(64);
			num_cols_q   <= lscf_pkg::GEO_W'(64);
			brightness_q <= '0;
			invert_q     <= 1'b0;
			enable_q     <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (lscf_pkg::cfg_reg_t'(cfg_index))
				lscf_pkg::REG_NUM_ROWS:   num_rows_q   <= cfg_data[lscf_pkg::GEO_W-1:0];
				lscf_pkg::REG_NUM_COLS:   num_cols_q   <= cfg_data[lscf_pkg::GEO_W-1:0];
				lscf_pkg::REG_BRIGHTNESS: brightness_q <= cfg_data;
				lscf_pkg::REG_INVERT:     invert_q     <= cfg_data[0];
				lscf_pkg::REG_ENABLE:     enable_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.rows = (num_rows_q > lscf_pkg::GEO_W'(lscf_pkg::MAX_ROWS)) ?
			lscf_pkg::GEO_W'(lscf_pkg::MAX_ROWS) : num_rows_q;
		cfg.cols = (num_cols_q > lscf_pkg::GEO_W'(lscf_pkg::MAX_COLS)) ?
			lscf_pkg::GEO_W'(lscf_pkg::MAX_COLS) : num_cols_q;
		cfg.brightness = brightness_q;
		cfg.invert     = invert_q;
		cfg.enable     = enable_q;
	end

endmodule

// File: rtl/core/lscf_obuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lscf_obuf
// Output register that holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
module lscf_obuf (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           res_vld,
	input  lscf_pkg::res_t res,
	output logic           slot_free,
	output logic           out_valid,
	input  logic           out_stall,
	output lscf_pkg::res_t res_q
);

	logic valid_q;

	assign slot_free = !valid_q || !out_stall;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (slot_free) begin
			valid_q <= res_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && res_vld) begin
			res_q <= res;
		end
	end

endmodule

// File: rtl/core/lscf_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lscf_engine
// Command sequencer: pixel read-modify-write, clear sweep and column refresh
// over the byte store.
// ----------------------------------------------------------------------------
module lscf_engine (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  op,
	input  logic [lscf_pkg::GEO_W-1:0]  col,
	input  logic [lscf_pkg::GEO_W-1:0]  row,
	input  logic                        pixel_on,
	input  lscf_pkg::cfg_t              cfg,
	input  logic                        slot_free,
	output logic                        res_vld,
	output lscf_pkg::res_t              res,
	output lscf_pkg::ram_req_t          ram_req,
	input  logic [7:0]                  rd_data
);

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_PIX   = 5'b00100,
		ST_FETCH = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	state_t                          state_q;
	logic [lscf_pkg::AW-1:0]         clr_addr_q;
	logic [lscf_pkg::CIDX_W-1:0]     cc_q;
	logic [lscf_pkg::KCNT_W-1:0]     k_q;
	logic                            valid_s1;
	logic [lscf_pkg::KCNT_W-1:0]     k_s1;

	lscf_pkg::op_t                   op_q;
	logic [lscf_pkg::AW-1:0]         addr_q;
	logic [2:0]                      bitpos_q;
	logic                            hit_q;
	logic                            on_q;
	logic [lscf_pkg::AW-1:0]         base_q;
	logic [7:0]                      lane_q [lscf_pkg::ROW_BYTES];

	lscf_pkg::op_t                   op_in;
	logic                            acc;
	logic [lscf_pkg::ADDR_SUM_W-1:0] in_sum;
	logic                            in_hit;
	logic [lscf_pkg::GEO_W-1:0]      next_cc;
	logic [lscf_pkg::ADDR_SUM_W-1:0] next_sum;
	logic [lscf_pkg::KCNT_W-1:0]     nbytes;
	logic [7:0]                      mask;
	logic [lscf_pkg::MAX_ROWS-1:0]   word;
	logic                            refresh_go;
	logic                            fetch_done;

	assign op_in    = lscf_pkg::op_t'(op);
	assign in_stall = (state_q != ST_IDLE);
	assign acc      = in_valid && !in_stall;

	assign in_sum = lscf_pkg::locate_addr(col, row, cfg.rows);
	assign in_hit = (col < cfg.cols) && (row < cfg.rows) &&
		(in_sum < lscf_pkg::ADDR_SUM_W'(lscf_pkg::DEPTH));

	// column whose base address is loaded when a column fetch starts
	assign next_cc  = (state_q == ST_IDLE) ? (cfg.cols - lscf_pkg::GEO_W'(1)) :
		(lscf_pkg::GEO_W'(cc_q) - lscf_pkg::GEO_W'(1));
	assign next_sum = lscf_pkg::locate_addr(next_cc, '0, cfg.rows);

	assign nbytes = lscf_pkg::KCNT_W'(({1'b0, cfg.rows} + 8'd7) >> 3);
	assign mask   = 8'h80 >> bitpos_q;

	assign refresh_go = acc && (op_in == lscf_pkg::OP_REFRESH) && cfg.enable &&
		(cfg.cols != '0);
	assign fetch_done = (k_q == nbytes);

	always_comb begin
		for (int b = 0; b < lscf_pkg::ROW_BYTES; b++) begin
			word[8*b +: 8] = lane_q[b];
		end
	end

	always_comb begin
		ram_req         = '0;
		ram_req.rd_addr = in_sum[lscf_pkg::AW-1:0];
		ram_req.wr_addr = clr_addr_q;
		res_vld         = 1'b0;
		res             = '0;
		case (state_q)
			ST_CLEAR: begin
				ram_req.wr_en = 1'b1;
			end
			ST_IDLE: begin
				if (acc && in_hit &&
					(op_in == lscf_pkg::OP_SET || op_in == lscf_pkg::OP_READ)) begin
					ram_req.rd_en = 1'b1;
				end
			end
			ST_PIX: begin
				if (op_q == lscf_pkg::OP_SET) begin
					ram_req.wr_en   = hit_q;
					ram_req.wr_addr = addr_q;
					ram_req.wr_data = on_q ? (rd_data | mask) : (rd_data & ~mask);
				end else if (slot_free) begin
					res_vld        = 1'b1;
					res.kind       = lscf_pkg::KIND_READ;
					res.pixel_read = hit_q && rd_data[3'd7 - bitpos_q];
				end
			end
			ST_FETCH: begin
				ram_req.rd_en   = !fetch_done;
				ram_req.rd_addr = base_q + lscf_pkg::AW'(k_q);
			end
			ST_EMIT: begin
				if (slot_free) begin
					res_vld          = 1'b1;
					res.kind         = lscf_pkg::KIND_SHIFT;
					res.column_bits  = lscf_pkg::BITS_W'(word);
					res.column_index = lscf_pkg::COLIDX_W'(cc_q);
					res.last         = (cc_q == '0);
					res.oe_duty      = (cc_q == '0) ? cfg.brightness : '0;
				end
			end
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
			cc_q       <= '0;
			k_q        <= '0;
			valid_s1   <= 1'b0;
		end else begin
			valid_s1 <= ram_req.rd_en && (state_q == ST_FETCH);
			case (state_q)
				ST_CLEAR: begin
					if (clr_addr_q == lscf_pkg::AW'(lscf_pkg::DEPTH - 1)) begin
						clr_addr_q <= '0;
						state_q    <= ST_IDLE;
					end else begin
						clr_addr_q <= clr_addr_q + lscf_pkg::AW'(1);
					end
				end
				ST_IDLE: begin
					if (acc) begin
						case (op_in)
							lscf_pkg::OP_SET, lscf_pkg::OP_READ: state_q <= ST_PIX;
							lscf_pkg::OP_CLEAR:                  state_q <= ST_CLEAR;
							lscf_pkg::OP_REFRESH: begin
								if (refresh_go) begin
									cc_q    <= lscf_pkg::CIDX_W'(next_cc);
									k_q     <= '0;
									state_q <= ST_FETCH;
								end
							end
							default: ;
						endcase
					end
				end
				ST_PIX: begin
					if (op_q == lscf_pkg::OP_SET || slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_FETCH: begin
					if (fetch_done) begin
						state_q <= ST_EMIT;
					end else begin
						k_q <= k_q + lscf_pkg::KCNT_W'(1);
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						if (cc_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							cc_q    <= lscf_pkg::CIDX_W'(next_cc);
							k_q     <= '0;
							state_q <= ST_FETCH;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		k_s1 <= k_q;
		if (state_q == ST_IDLE && acc) begin
			op_q     <= op_in;
			addr_q   <= in_sum[lscf_pkg::AW-1:0];
			bitpos_q <= row[2:0];
			hit_q    <= in_hit;
			on_q     <= pixel_on;
		end
		if ((state_q == ST_IDLE && refresh_go) ||
			(state_q == ST_EMIT && slot_free && cc_q != '0)) begin
			base_q <= next_sum[lscf_pkg::AW-1:0];
			for (int b = 0; b < lscf_pkg::ROW_BYTES; b++) begin
				lane_q[b] <= '0;
			end
		end else if (valid_s1) begin
			// byte bit 7-j is row 8k+j of the column
			for (int b = 0; b < lscf_pkg::ROW_BYTES; b++) begin
				if (k_s1 == lscf_pkg::KCNT_W'(b)) begin
					for (int j = 0; j < 8; j++) begin
						lane_q[b][j] <= (lscf_pkg::GEO_W'(8*b + j) < cfg.rows) ?
							(rd_data[7-j] ^ cfg.invert) : 1'b0;
					end
				end
			end
		end
	end

endmodule

// File: rtl/core/led_shift_chain_framebuffer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_shift_chain_framebuffer_top
// Packed one-bit framebuffer for a shift-register LED matrix chain.
// ----------------------------------------------------------------------------
// The frame lives in a 512 x 8 single-port-read RAM. After reset the block
// sweeps the RAM to zero with in_stall high, and a clear command does the
// same sweep. A set or read makes one RAM read, then the write-back or the
// answer. A refresh reads ceil(rows/8) bytes per column through the single
// read port, then emits the column, waiting while the sink stalls; a refresh
// with the display disabled or with no columns emits nothing. One command is
// in flight at a time, but a finished beat may wait in the output register
// while the next command is accepted.
// ----------------------------------------------------------------------------
module led_shift_chain_framebuffer_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [1:0]                         op,
	input  logic [lscf_pkg::GEO_W-1:0]         col,
	input  logic [lscf_pkg::GEO_W-1:0]         row,
	input  logic                               pixel_on,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               kind,
	output logic                               pixel_read,
	output logic [lscf_pkg::BITS_W-1:0]        column_bits,
	output logic [lscf_pkg::COLIDX_W-1:0]      column_index,
	output logic                               last,
	output logic [lscf_pkg::DUTY_W-1:0]        oe_duty,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [lscf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lscf_pkg::CFG_DATA_W-1:0]    cfg_data
);

	lscf_pkg::cfg_t     cfg;
	lscf_pkg::ram_req_t ram_req;
	lscf_pkg::res_t     res;
	lscf_pkg::res_t     res_q;
	logic               res_vld;
	logic               slot_free;
	logic [7:0]         rd_data;

	lscf_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lscf_ram #(
		.WIDTH (8),
		.DEPTH (lscf_pkg::DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (ram_req.wr_en),
		.wr_addr (ram_req.wr_addr),
		.wr_data (ram_req.wr_data),
		.rd_en   (ram_req.rd_en),
		.rd_addr (ram_req.rd_addr),
		.rd_data (rd_data)
	);

	lscf_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.col       (col),
		.row       (row),
		.pixel_on  (pixel_on),
		.cfg       (cfg),
		.slot_free (slot_free),
		.res_vld   (res_vld),
		.res       (res),
		.ram_req   (ram_req),
		.rd_data   (rd_data)
	);

	lscf_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_vld   (res_vld),
		.res       (res),
		.slot_free (slot_free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res_q     (res_q)
	);

	assign kind         = res_q.kind;
	assign pixel_read   = res_q.pixel_read;
	assign column_bits  = res_q.column_bits;
	assign column_index = res_q.column_index;
	assign last         = res_q.last;
	assign oe_duty      = res_q.oe_duty;

endmodule

// File: test/led_shift_chain_framebuffer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_shift_chain_framebuffer_top_tb
// Sends pixel set, read, clear and refresh commands under a range of display
// settings and checks every output beat against a bench copy of the packed
// framebuffer. The settings include the extremes, zero sizes, oversize sizes,
// row counts that are not a multiple of eight, and a blanked display. Both
// ports stall and idle at random, and the sink also holds off for a long
// stretch.
// ----------------------------------------------------------------------------
module led_shift_chain_framebuffer_top_tb;

	localparam int CLK_PERIOD     = 10;
	localparam int SETTLE_CYCLES  = 600;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int COORD_MAX      = 127;
	localparam int BYTE_BITS      = 8;
	localparam logic [7:0] TOP_ROW_MASK = 8'h80;
	localparam logic [lscf_pkg::CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
	localparam logic [lscf_pkg::CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_RANDOM,
		STALL_PATTERN
	} stall_mode_t;

	logic                            clk          = 1'b0;
	logic                            arst_n       = 1'b0;
	logic                            in_valid     = 1'b0;
	logic                            in_stall;
	logic [1:0]                      op           = lscf_pkg::OP_SET;
	logic [lscf_pkg::GEO_W-1:0]      col          = '0;
	logic [lscf_pkg::GEO_W-1:0]      row          = '0;
	logic                            pixel_on     = 1'b0;
	logic                            out_valid;
	logic                            out_stall    = 1'b0;
	logic                            kind;
	logic                            pixel_read;
	logic [lscf_pkg::BITS_W-1:0]     column_bits;
	logic [lscf_pkg::COLIDX_W-1:0]   column_index;
	logic                            last;
	logic [lscf_pkg::DUTY_W-1:0]     oe_duty;
	logic                            cfg_valid    = 1'b0;
	logic                            cfg_ready;
	logic [lscf_pkg::CFG_IDX_W-1:0]  cfg_index    = lscf_pkg::REG_NUM_ROWS;
	logic [lscf_pkg::CFG_DATA_W-1:0] cfg_data     = '0;

	// bench copy of the frame and settings
	logic [7:0]                  frame_bytes [lscf_pkg::DEPTH];
	logic [lscf_pkg::GEO_W-1:0]  set_rows   = 7'd64;
	logic [lscf_pkg::GEO_W-1:0]  set_cols   = 7'd64;
	logic [lscf_pkg::DUTY_W-1:0] set_bright = '0;
	logic                        set_invert = 1'b0;
	logic                        set_enable = 1'b1;
	lscf_pkg::res_t              due_beats [$];

	stall_mode_t stall_mode = STALL_NONE;
	int          stall_phase = 0;
	int          hold_req = 0;
	int          hold_ack = 0;
	int          hold_left = 0;
	int          quiet_cycles = 0;
	int          burst_left = 0;
	int          gap_max = 0;
	int          mismatches = 0;
	int          commands_sent = 0;
	int          reg_writes = 0;
	int          read_answers = 0;
	int          shift_words = 0;

	led_shift_chain_framebuffer_top uut (.*);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic void wipe_frame();
		foreach (frame_bytes[i])
			frame_bytes[i] = '0;
	endfunction

	function automatic int active_rows_now();
		return (set_rows > lscf_pkg::MAX_ROWS) ? lscf_pkg::MAX_ROWS : int'(set_rows);
	endfunction

	function automatic int active_cols_now();
		return (set_cols > lscf_pkg::MAX_COLS) ? lscf_pkg::MAX_COLS : int'(set_cols);
	endfunction

	function automatic logic pixel_spot(input int c, input int r, output int addr,
			output logic [7:0] mask);
		int rows;
		rows = active_rows_now();
		addr = 0;
		mask = '0;
		if (c >= active_cols_now() || r >= rows)
			return 1'b0;
		addr = (c * rows) / BYTE_BITS + r / BYTE_BITS;
		if (addr >= lscf_pkg::DEPTH)
			return 1'b0;
		mask = TOP_ROW_MASK >> (r % BYTE_BITS);
		return 1'b1;
	endfunction

	function automatic logic pixel_value(input int c, input int r);
		int addr;
		logic [7:0] mask;
		if (!pixel_spot(c, r, addr, mask))
			return 1'b0;
		return |(frame_bytes[addr] & mask);
	endfunction

	function automatic void apply_command(input lscf_pkg::op_t o, input int c,
			input int r, input logic on);
		int addr;
		int cc;
		int rr;
		logic [7:0] mask;
		lscf_pkg::res_t beat;
		case (o)
			lscf_pkg::OP_SET: begin
				if (pixel_spot(c, r, addr, mask))
					frame_bytes[addr] = on ? (frame_bytes[addr] | mask)
						: (frame_bytes[addr] & ~mask);
			end
			lscf_pkg::OP_READ: begin
				beat = '0;
				beat.kind = lscf_pkg::KIND_READ;
				beat.pixel_read = pixel_value(c, r);
				due_beats.push_back(beat);
			end
			lscf_pkg::OP_CLEAR: wipe_frame();
			default: begin
				if (set_enable) begin
					for (cc = active_cols_now() - 1; cc >= 0; cc--) begin
						beat = '0;
						beat.kind = lscf_pkg::KIND_SHIFT;
						for (rr = 0; rr < active_rows_now(); rr++)
							beat.column_bits[rr] = pixel_value(cc, rr) ^ set_invert;
						beat.column_index = lscf_pkg::COLIDX_W'(cc);
						beat.last = (cc == 0);
						beat.oe_duty = (cc == 0) ? set_bright : '0;
						due_beats.push_back(beat);
					end
				end
			end
		endcase
	endfunction

	function automatic void compare_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : beat_check
		lscf_pkg::res_t want;
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			if (due_beats.size() == 0) begin
				$error("unexpected beat: kind %0b column_index %0d", kind, column_index);
				mismatches++;
			end else begin
				want = due_beats.pop_front();
				if (want.kind == lscf_pkg::KIND_SHIFT)
					shift_words++;
				else
					read_answers++;
				compare_field("kind", want.kind, kind);
				compare_field("pixel_read", want.pixel_read, pixel_read);
				compare_field("column_bits", want.column_bits, column_bits);
				compare_field("column_index", want.column_index, column_index);
				compare_field("last", want.last, last);
				compare_field("oe_duty", want.oe_duty, oe_duty);
			end
		end
	end

	// sink stall: long hold on request, otherwise the current pattern
	always @(posedge clk) begin
		stall_phase <= stall_phase + 1;
		if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			case (stall_mode)
				STALL_RANDOM:  out_stall <= ($urandom_range(0, 99) < 35);
				STALL_PATTERN: out_stall <= ((stall_phase % 11) < 4);
				default:       out_stall <= 1'b0;
			endcase
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("led_shift_chain_framebuffer_top_tb failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_cmd(input lscf_pkg::op_t o, input int c, input int r,
			input logic on);
		in_valid <= 1'b1;
		op <= o;
		col <= lscf_pkg::GEO_W'(c);
		row <= lscf_pkg::GEO_W'(r);
		pixel_on <= on;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		apply_command(o, c, r, on);
		commands_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 24);
			if (gap_max > 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, gap_max)) @(posedge clk);
			end
		end
	endtask

	function automatic int pick_coord(input int span);
		if (span > 0 && $urandom_range(0, 9) < 8)
			return $urandom_range(0, span - 1);
		return $urandom_range(0, COORD_MAX);
	endfunction

	task automatic run_random(input int count);
		int pick;
		lscf_pkg::op_t o;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < 3)
				o = lscf_pkg::OP_CLEAR;
			else if (pick < 15)
				o = lscf_pkg::OP_REFRESH;
			else if (pick < 45)
				o = lscf_pkg::OP_READ;
			else
				o = lscf_pkg::OP_SET;
			send_cmd(o, pick_coord(active_cols_now()), pick_coord(active_rows_now()),
				1'($urandom));
		end
	endtask

	// stop sending, wait for every beat, then give a clear sweep time to finish
	task automatic drain_results();
		in_valid <= 1'b0;
		while (due_beats.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [lscf_pkg::CFG_IDX_W-1:0] idx,
			input logic [lscf_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (cfg_ready !== 1'b1)
			@(posedge clk);
		case (idx)
			lscf_pkg::REG_NUM_ROWS:   set_rows = data[lscf_pkg::GEO_W-1:0];
			lscf_pkg::REG_NUM_COLS:   set_cols = data[lscf_pkg::GEO_W-1:0];
			lscf_pkg::REG_BRIGHTNESS: set_bright = data;
			lscf_pkg::REG_INVERT:     set_invert = data[0];
			lscf_pkg::REG_ENABLE:     set_enable = data[0];
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic load_settings(input logic [7:0] rows, input logic [7:0] cols,
			input logic [7:0] bright, input logic inv, input logic en,
			input bit with_spares);
		int k;
		drain_results();
		write_reg(lscf_pkg::REG_NUM_ROWS, rows);
		write_reg(lscf_pkg::REG_NUM_COLS, cols);
		write_reg(lscf_pkg::REG_BRIGHTNESS, bright);
		write_reg(lscf_pkg::REG_INVERT, {7'($urandom), inv});
		write_reg(lscf_pkg::REG_ENABLE, {7'($urandom), en});
		if (with_spares) begin
			for (k = REG_SPARE_FIRST; k <= REG_SPARE_LAST; k++)
				write_reg(lscf_pkg::CFG_IDX_W'(k), 8'($urandom) | 8'h81);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic test_reset_defaults();
		stall_mode <= STALL_NONE;
		gap_max = 0;
		send_cmd(lscf_pkg::OP_SET, 0, 0, 1'b1);
		send_cmd(lscf_pkg::OP_SET, lscf_pkg::MAX_COLS - 1, lscf_pkg::MAX_ROWS - 1, 1'b1);
		send_cmd(lscf_pkg::OP_SET, lscf_pkg::MAX_COLS - 1, 0, 1'b1);
		send_cmd(lscf_pkg::OP_SET, 0, lscf_pkg::MAX_ROWS - 1, 1'b1);
		send_cmd(lscf_pkg::OP_SET, COORD_MAX, COORD_MAX, 1'b1);
		send_cmd(lscf_pkg::OP_READ, 0, 0, 1'b0);
		send_cmd(lscf_pkg::OP_READ, lscf_pkg::MAX_COLS - 1, lscf_pkg::MAX_ROWS - 1, 1'b0);
		send_cmd(lscf_pkg::OP_READ, lscf_pkg::MAX_COLS, 0, 1'b1);
		send_cmd(lscf_pkg::OP_READ, 0, lscf_pkg::MAX_ROWS, 1'b1);
		send_cmd(lscf_pkg::OP_REFRESH, 0, 0, 1'b0);
		send_cmd(lscf_pkg::OP_SET, lscf_pkg::MAX_COLS - 1, lscf_pkg::MAX_ROWS - 1, 1'b0);
		send_cmd(lscf_pkg::OP_READ, lscf_pkg::MAX_COLS - 1, lscf_pkg::MAX_ROWS - 1, 1'b0);
		send_cmd(lscf_pkg::OP_CLEAR, COORD_MAX, COORD_MAX, 1'b1);
		send_cmd(lscf_pkg::OP_READ, 0, 0, 1'b0);
		send_cmd(lscf_pkg::OP_REFRESH, 0, 0, 1'b0);
		stall_mode <= STALL_RANDOM;
		gap_max = 6;
		run_random(50);
	endtask

	// sink holds off while commands keep coming, then the sender waits it out
	task automatic test_output_hold();
		drain_results();
		stall_mode <= STALL_NONE;
		hold_req <= hold_req + 1;
		gap_max = 0;
		repeat (6)
			send_cmd(lscf_pkg::OP_READ, pick_coord(lscf_pkg::MAX_COLS),
				pick_coord(lscf_pkg::MAX_ROWS), 1'b0);
		send_cmd(lscf_pkg::OP_REFRESH, 0, 0, 1'b0);
		repeat (4)
			send_cmd(lscf_pkg::OP_SET, pick_coord(lscf_pkg::MAX_COLS),
				pick_coord(lscf_pkg::MAX_ROWS), 1'b1);
		drain_results();
		stall_mode <= STALL_PATTERN;
		gap_max = 3;
		run_random(20);
	endtask

	task automatic test_small_frame();
		load_settings(8'd8, 8'd8, 8'hFF, 1'b1, 1'b1, 1'b0);
		stall_mode <= STALL_PATTERN;
		gap_max = 8;
		run_random(45);
	endtask

	// five rows: column one starts inside the byte of column zero
	task automatic test_odd_rows();
		load_settings(8'd5, 8'd13, 8'h5A, 1'b0, 1'b1, 1'b0);
		stall_mode <= STALL_NONE;
		gap_max = 0;
		send_cmd(lscf_pkg::OP_SET, 1, 0, 1'b1);
		send_cmd(lscf_pkg::OP_READ, 0, 0, 1'b0);
		send_cmd(lscf_pkg::OP_REFRESH, 0, 0, 1'b0);
		run_random(45);
	endtask

	task automatic test_oversize_geometry();
		load_settings(8'd200, 8'd127, 8'h01, 1'b1, 1'b1, 1'b0);
		stall_mode <= STALL_RANDOM;
		gap_max = 4;
		send_cmd(lscf_pkg::OP_SET, lscf_pkg::MAX_COLS - 1, lscf_pkg::MAX_ROWS - 1, 1'b1);
		send_cmd(lscf_pkg::OP_READ, lscf_pkg::MAX_COLS - 1, lscf_pkg::MAX_ROWS - 1, 1'b0);
		send_cmd(lscf_pkg::OP_READ, lscf_pkg::MAX_COLS, lscf_pkg::MAX_ROWS, 1'b0);
		run_random(35);
	endtask

	task automatic test_zero_geometry();
		load_settings(8'd0, 8'd7, 8'h80, 1'b1, 1'b1, 1'b0);
		stall_mode <= STALL_PATTERN;
		gap_max = 5;
		send_cmd(lscf_pkg::OP_SET, 0, 0, 1'b1);
		send_cmd(lscf_pkg::OP_READ, 0, 0, 1'b0);
		send_cmd(lscf_pkg::OP_REFRESH, 0, 0, 1'b0);
		run_random(20);
		load_settings(8'd20, 8'd0, 8'h33, 1'b0, 1'b1, 1'b0);
		send_cmd(lscf_pkg::OP_REFRESH, 0, 0, 1'b0);
		send_cmd(lscf_pkg::OP_READ, 0, 0, 1'b0);
		run_random(15);
	endtask

	task automatic test_display_off();
		load_settings(8'd64, 8'd64, 8'hC3, 1'b0, 1'b0, 1'b0);
		stall_mode <= STALL_RANDOM;
		gap_max = 2;
		send_cmd(lscf_pkg::OP_REFRESH, 0, 0, 1'b0);
		send_cmd(lscf_pkg::OP_SET, 5, 5, 1'b1);
		send_cmd(lscf_pkg::OP_READ, 5, 5, 1'b0);
		run_random(25);
	endtask

	task automatic test_spare_indexes();
		load_settings(8'd16, 8'd12, 8'hFF, 1'b0, 1'b1, 1'b1);
		stall_mode <= STALL_NONE;
		gap_max = 3;
		send_cmd(lscf_pkg::OP_REFRESH, 0, 0, 1'b0);
		run_random(25);
	endtask

	task automatic test_random_settings();
		int k;
		for (k = 0; k < 3; k++) begin
			load_settings(8'($urandom_range(1, 64)), 8'($urandom_range(1, 64)),
				8'($urandom), 1'($urandom), 1'b1, 1'b0);
			stall_mode <= (k == 1) ? STALL_PATTERN : STALL_RANDOM;
			gap_max = 2 * k + 1;
			run_random(20);
		end
	endtask

	initial begin
		wipe_frame();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_output_hold();
		test_small_frame();
		test_odd_rows();
		test_oversize_geometry();
		test_zero_geometry();
		test_display_off();
		test_spare_indexes();
		test_random_settings();
		drain_results();
		$display("ran %0d commands and %0d register writes across default, tiny, odd, oversize,",
			commands_sent, reg_writes);
		$display("zero, blanked and random frames; checked %0d read beats, %0d shift beats",
			read_answers, shift_words);
		if (mismatches == 0)
			$display("led_shift_chain_framebuffer_top_tb passed");
		else
			$display("led_shift_chain_framebuffer_top_tb failed");
		$finish;
	end

endmodule
